// ===== rtl/core/stmn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmn_pkg: shared types and constants for the slot table
// Table geometry, command and status codes, sequencer states and the
// structs that pass between the controller, the entry RAM and the top level.
// ----------------------------------------------------------------------------
package stmn_pkg;

	// Table geometry
	localparam int SLOTS      = 64;
	localparam int ENTRY_BITS = 32;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int IDX_W      = 6;
	localparam int DATA_W     = 32;

	localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

	// Command codes
	typedef enum logic [2:0] {
		CMD_ADD      = 3'd0,
		CMD_REM_VAL  = 3'd1,
		CMD_REM_NTH  = 3'd2,
		CMD_REPLACE  = 3'd3,
		CMD_READ_NTH = 3'd4,
		CMD_NEXT     = 3'd5,
		CMD_REWIND   = 3'd6,
		CMD_CLEAR    = 3'd7
	} cmd_t;

	// Result status codes
	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_NOT_FOUND = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_INDEX     = 3'd3,
		STAT_END       = 3'd4
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_FREE,
		S_MATCH,
		S_NTH,
		S_NEXT,
		S_READ,
		S_RESP
	} state_t;

	// Entry RAM request
	typedef struct packed {
		logic                  we;
		logic [SLOT_W-1:0]     addr;
		logic [ENTRY_BITS-1:0] wdata;
	} mem_req_t;

	// Finished result handed to the output register
	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] data;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  count;
		logic              at_end;
	} result_t;

endpackage

// ===== rtl/core/stmn_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmn_ram: entry word storage
// Single-port synchronous RAM, one write or one read per cycle, read data
// registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module stmn_ram (
	input  logic                            clk,
	input  stmn_pkg::mem_req_t              req,
	output logic [stmn_pkg::ENTRY_BITS-1:0] rdata
);
	import stmn_pkg::*;

	logic [ENTRY_BITS-1:0] mem [SLOTS];

	// Write or read the addressed entry
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else begin
			rdata <= mem[req.addr];
		end
	end

endmodule

// ===== rtl/core/stmn_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmn_ctrl: command sequencer for the slot table
// Holds valid bits, count and cursor, and walks the slots one per cycle to
// find a free slot, a matching entry, the nth valid entry or the next one.
// ----------------------------------------------------------------------------
module stmn_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      cmd,
	input  logic [31:0]                     value,
	input  logic [31:0]                     new_value,
	input  logic [stmn_pkg::IDX_W-1:0]      index,
	output logic                            res_valid,
	input  logic                            res_take,
	output stmn_pkg::result_t               res,
	output stmn_pkg::mem_req_t              mem_req,
	input  logic [stmn_pkg::ENTRY_BITS-1:0] mem_rdata
);
	import stmn_pkg::*;

	// Control state
	state_t            state_q, state_d;
	logic [SLOTS-1:0]  valid_q, valid_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  cursor_q, cursor_d;
	logic              chk_vld_s1, chk_vld_d;

	// Command and scan payload
	cmd_t                  cmd_q, cmd_d;
	logic [ENTRY_BITS-1:0] val_q, val_d;
	logic [ENTRY_BITS-1:0] nval_q, nval_d;
	logic [IDX_W-1:0]      idx_q, idx_d;
	logic [CNT_W-1:0]      scan_q, scan_d;
	logic [CNT_W-1:0]      seen_q, seen_d;
	logic [SLOT_W-1:0]     chk_addr_s1, chk_addr_d;
	status_t               res_status_q, res_status_d;
	logic [DATA_W-1:0]     res_data_q, res_data_d;
	logic [SLOT_W-1:0]     res_slot_q, res_slot_d;

	logic [SLOT_W-1:0] scan_addr;
	logic              scan_done;
	logic              match;
	logic [SLOTS-1:0]  above_mask;

	assign scan_addr = scan_q[SLOT_W-1:0];
	assign scan_done = (scan_q == SLOTS_CNT);
	assign match     = chk_vld_s1 && valid_q[chk_addr_s1] && (mem_rdata == val_q);

	// Slots at or after the cursor
	assign above_mask = ~((SLOTS'(1) << cursor_q) - SLOTS'(1));

	assign res.status = res_status_q;
	assign res.data   = res_data_q;
	assign res.slot   = res_slot_q;
	assign res.count  = count_q;
	assign res.at_end = ~|(valid_q & above_mask);

	// Next state and sequencing
	always_comb begin
		state_d      = state_q;
		valid_d      = valid_q;
		count_d      = count_q;
		cursor_d     = cursor_q;
		chk_vld_d    = 1'b0;
		chk_addr_d   = scan_addr;
		cmd_d        = cmd_q;
		val_d        = val_q;
		nval_d       = nval_q;
		idx_d        = idx_q;
		scan_d       = scan_q;
		seen_d       = seen_q;
		res_status_d = res_status_q;
		res_data_d   = res_data_q;
		res_slot_d   = res_slot_q;
		mem_req.we    = 1'b0;
		mem_req.addr  = scan_addr;
		mem_req.wdata = val_q;
		in_stall      = (state_q != S_IDLE);
		res_valid     = (state_q == S_RESP);

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_d        = cmd_t'(cmd);
					val_d        = value[ENTRY_BITS-1:0];
					nval_d       = new_value[ENTRY_BITS-1:0];
					idx_d        = index;
					res_status_d = STAT_OK;
					res_data_d   = '0;
					res_slot_d   = '0;
					scan_d       = '0;
					seen_d       = '0;
					unique case (cmd_t'(cmd)) inside
						CMD_ADD: begin
							if (count_q == SLOTS_CNT) begin
								res_status_d = STAT_FULL;
								state_d      = S_RESP;
							end else begin
								state_d = S_FREE;
							end
						end
						CMD_REM_VAL, CMD_REPLACE: begin
							state_d = S_MATCH;
						end
						CMD_REM_NTH, CMD_READ_NTH: begin
							cursor_d = '0;
							if (CNT_W'(index) >= count_q) begin
								res_status_d = STAT_INDEX;
								state_d      = S_RESP;
							end else begin
								state_d = S_NTH;
							end
						end
						CMD_NEXT: begin
							scan_d  = cursor_q;
							state_d = S_NEXT;
						end
						CMD_REWIND: begin
							cursor_d = '0;
							state_d  = S_RESP;
						end
						CMD_CLEAR: begin
							valid_d  = '0;
							count_d  = '0;
							cursor_d = '0;
							state_d  = S_RESP;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end

			// Walk to the lowest free slot and write the entry there
			S_FREE: begin
				if (scan_done) begin
					res_status_d = STAT_FULL;
					state_d      = S_RESP;
				end else if (!valid_q[scan_addr]) begin
					mem_req.we          = 1'b1;
					valid_d[scan_addr]  = 1'b1;
					count_d             = count_q + CNT_W'(1);
					cursor_d            = scan_q + CNT_W'(1);
					res_slot_d          = scan_addr;
					state_d             = S_RESP;
				end else begin
					scan_d = scan_q + CNT_W'(1);
				end
			end

			// Read one entry per cycle and compare it in the next cycle
			S_MATCH: begin
				if (match) begin
					res_slot_d = chk_addr_s1;
					if (cmd_q == CMD_REM_VAL) begin
						valid_d[chk_addr_s1] = 1'b0;
						count_d              = count_q - CNT_W'(1);
					end else begin
						mem_req.we    = 1'b1;
						mem_req.addr  = chk_addr_s1;
						mem_req.wdata = nval_q;
					end
					state_d = S_RESP;
				end else if (scan_done) begin
					if (!chk_vld_s1) begin
						res_status_d = STAT_NOT_FOUND;
						state_d      = S_RESP;
					end
				end else begin
					chk_vld_d = 1'b1;
					scan_d    = scan_q + CNT_W'(1);
				end
			end

			// Count valid slots up to the requested position
			S_NTH: begin
				if (scan_done) begin
					res_status_d = STAT_INDEX;
					state_d      = S_RESP;
				end else begin
					if (valid_q[scan_addr]) begin
						if (seen_q == CNT_W'(idx_q)) begin
							res_slot_d = scan_addr;
							cursor_d   = scan_q + CNT_W'(1);
							if (cmd_q == CMD_REM_NTH) begin
								valid_d[scan_addr] = 1'b0;
								count_d            = count_q - CNT_W'(1);
								state_d            = S_RESP;
							end else begin
								state_d = S_READ;
							end
						end else begin
							seen_d = seen_q + CNT_W'(1);
						end
					end
					scan_d = scan_q + CNT_W'(1);
				end
			end

			// Advance from the cursor to the next valid slot
			S_NEXT: begin
				if (scan_done) begin
					res_status_d = STAT_END;
					cursor_d     = SLOTS_CNT;
					state_d      = S_RESP;
				end else if (valid_q[scan_addr]) begin
					res_slot_d = scan_addr;
					cursor_d   = scan_q + CNT_W'(1);
					state_d    = S_READ;
				end else begin
					scan_d = scan_q + CNT_W'(1);
				end
			end

			// Capture the entry read in the previous cycle
			S_READ: begin
				res_data_d = DATA_W'(mem_rdata);
				state_d    = S_RESP;
			end

			// Hold the result until the output register takes it
			S_RESP: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			count_q    <= '0;
			cursor_q   <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			valid_q    <= valid_d;
			count_q    <= count_d;
			cursor_q   <= cursor_d;
			chk_vld_s1 <= chk_vld_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		val_q        <= val_d;
		nval_q       <= nval_d;
		idx_q        <= idx_d;
		scan_q       <= scan_d;
		seen_q       <= seen_d;
		chk_addr_s1  <= chk_addr_d;
		res_status_q <= res_status_d;
		res_data_q   <= res_data_d;
		res_slot_q   <= res_slot_d;
	end

endmodule

// ===== rtl/core/slot_table_with_match_and_nth_top.sv =====
`timescale 1ns / 1ps
// Flow: rewind, clear, add on a full table and index errors go straight to the result;
//   a scan command first walks the slots, and every result then passes through the
//   output register.
// Throughput: one item at a time; the sequencer walk over the slots, one slot per
//   cycle, sets the rate unless out_stall holds a result back.
// Reset: arst_n clears valid bits, count, cursor and handshakes; the entry RAM is not
//   cleared, no clearing pass.
// ----------------------------------------------------------------------------
// slot_table_with_match_and_nth_top: slot table with match and nth lookup
// Command sequencer, entry RAM and a registered result stage that lets a new
// item enter while the previous result waits.
// ----------------------------------------------------------------------------
module slot_table_with_match_and_nth_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   cmd,
	input  logic [31:0]                  value,
	input  logic [31:0]                  new_value,
	input  logic [stmn_pkg::IDX_W-1:0]   index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   status,
	output logic [stmn_pkg::DATA_W-1:0]  data,
	output logic [stmn_pkg::SLOT_W-1:0]  slot,
	output logic [stmn_pkg::CNT_W-1:0]   count,
	output logic                         at_end
);
	import stmn_pkg::*;

	mem_req_t              mem_req;
	logic [ENTRY_BITS-1:0] mem_rdata;
	result_t               res;
	logic                  res_valid;
	logic                  res_take;
	logic                  out_valid_q;
	result_t               out_q;

	stmn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.value     (value),
		.new_value (new_value),
		.index     (index),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	stmn_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// Load the output register when it is empty or being drained
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result item
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign data      = out_q.data;
	assign slot      = out_q.slot;
	assign count     = out_q.count;
	assign at_end    = out_q.at_end;

endmodule

// ===== bench/tb_slot_table_with_match_and_nth_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_table_with_match_and_nth_top: self-checking bench for the slot table
// A queue of commands feeds a clocked driver. A clocked monitor keeps a
// shadow table, predicts the result of every accepted item and checks each
// returned result against the oldest prediction. A directed opening covers
// the corner cases. Random phases then fill, walk and drain the table, with
// idle and stall bursts, one long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_slot_table_with_match_and_nth_top;
	import stmn_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int QUIET_TAIL   = 150;   // last items run with no idling
	localparam int HOLD_AT      = 500;   // accepted items before the long hold-off
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 4 * SLOTS;
	localparam int DOG_LIMIT    = 4000;

	// Command mix of one random phase
	typedef enum int {
		MIX_FILL,
		MIX_WALK,
		MIX_DRAIN,
		MIX_ANY
	} mix_t;

	typedef struct {
		cmd_t        op;
		logic [31:0] value;
		logic [31:0] new_value;
		logic [5:0]  index;
		bit          drain_first;
	} table_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] cmd = CMD_REWIND;
	logic [31:0] value = '0;
	logic [31:0] new_value = '0;
	logic [IDX_W-1:0] index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [DATA_W-1:0] data;
	logic [SLOT_W-1:0] slot;
	logic [CNT_W-1:0] count;
	logic at_end;

	slot_table_with_match_and_nth_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.value(value),
		.new_value(new_value),
		.index(index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data(data),
		.slot(slot),
		.count(count),
		.at_end(at_end)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the table
	bit          slot_live [SLOTS];
	logic [31:0] slot_word [SLOTS];
	int          walk_pos;
	int          live_count;

	table_cmd_t cmd_q [$];
	result_t    want_q [$];
	logic [31:0] value_pool [8];

	int errors = 0;
	int in_count = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit in_took = 1'b0;
	int dog_cycles = 0;
	table_cmd_t drv_item;
	result_t want;

	task automatic report_error(input string msg);
		errors++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// lowest live slot at or after start, SLOTS if none
	function automatic int first_live_from(int start);
		int s;
		s = SLOTS;
		for (int i = SLOTS - 1; i >= start; i--)
			if (slot_live[i])
				s = i;
		return s;
	endfunction

	// Apply one command to the shadow table and return its result
	function automatic result_t apply_command(cmd_t op, logic [31:0] val, logic [31:0] nval,
			logic [5:0] idx);
		result_t r;
		int s;
		int seen;
		r.status = STAT_OK;
		r.data = '0;
		r.slot = '0;
		s = SLOTS;
		seen = 0;
		case (op)
			CMD_ADD: begin
				for (int i = 0; i < SLOTS; i++)
					if (!slot_live[i] && s == SLOTS)
						s = i;
				if (live_count >= SLOTS || s >= SLOTS) begin
					r.status = STAT_FULL;
				end else begin
					slot_word[s] = val;
					slot_live[s] = 1'b1;
					live_count++;
					walk_pos = s + 1;
					r.slot = s[5:0];
				end
			end
			CMD_REM_VAL, CMD_REPLACE: begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_live[i] && slot_word[i] == val && s == SLOTS)
						s = i;
				if (s >= SLOTS) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					if (op == CMD_REM_VAL) begin
						slot_live[s] = 1'b0;
						live_count--;
					end else begin
						slot_word[s] = nval;
					end
					r.slot = s[5:0];
				end
			end
			CMD_REM_NTH, CMD_READ_NTH: begin
				walk_pos = 0;
				if (idx >= live_count) begin
					r.status = STAT_INDEX;
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (slot_live[i]) begin
							if (seen == idx && s == SLOTS)
								s = i;
							seen++;
						end
					walk_pos = s + 1;
					r.slot = s[5:0];
					if (op == CMD_REM_NTH) begin
						slot_live[s] = 1'b0;
						live_count--;
					end else begin
						r.data = slot_word[s];
					end
				end
			end
			CMD_NEXT: begin
				s = first_live_from(walk_pos);
				if (s >= SLOTS) begin
					r.status = STAT_END;
					walk_pos = SLOTS;
				end else begin
					r.data = slot_word[s];
					r.slot = s[5:0];
					walk_pos = s + 1;
				end
			end
			CMD_REWIND: begin
				walk_pos = 0;
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					slot_live[i] = 1'b0;
				live_count = 0;
				walk_pos = 0;
			end
		endcase
		r.count = live_count[CNT_W-1:0];
		r.at_end = (first_live_from(walk_pos) >= SLOTS);
		return r;
	endfunction

	task automatic queue_cmd(input cmd_t op, input logic [31:0] val, input logic [31:0] nval,
			input logic [5:0] idx, input bit drain);
		table_cmd_t c;
		c.op = op;
		c.value = val;
		c.new_value = nval;
		c.index = idx;
		c.drain_first = drain;
		cmd_q.push_back(c);
	endtask

	// Mostly pooled values so that matches happen, sometimes any word
	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 3) != 0)
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic cmd_t pick_op(mix_t mix);
		int p;
		p = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:
				return (p < 80) ? CMD_ADD : cmd_t'($urandom_range(1, 6));
			MIX_WALK:
				if (p < 40)
					return CMD_NEXT;
				else if (p < 60)
					return CMD_READ_NTH;
				else if (p < 70)
					return CMD_REWIND;
				else if (p < 85)
					return CMD_ADD;
				else
					return CMD_REPLACE;
			MIX_DRAIN:
				if (p < 35)
					return CMD_REM_VAL;
				else if (p < 70)
					return CMD_REM_NTH;
				else if (p < 80)
					return CMD_REPLACE;
				else
					return cmd_t'($urandom_range(3, 6));
			default:
				return cmd_t'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic queue_phase(input mix_t mix, input int len);
		logic [5:0] idx;
		for (int i = 0; i < len; i++) begin
			idx = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 7));
			queue_cmd(pick_op(mix), pick_value(), pick_value(), idx, 1'b0);
		end
	endtask

	// Drive items at the falling edge; hold an item until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// hold the offered item
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (cmd_q.size() == 0 || (cmd_q[0].drain_first && want_q.size() != 0)) begin
			in_valid <= 1'b0;
		end else if (cmd_q.size() >= QUIET_TAIL && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			gap_left <= $urandom_range(1, 19) - 1;
		end else begin
			drv_item = cmd_q.pop_front();
			cmd <= drv_item.op;
			value <= drv_item.value;
			new_value <= drv_item.new_value;
			index <= drv_item.index;
			in_valid <= 1'b1;
		end
	end

	// Output stall: one long hold-off and random bursts until the tail
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && in_count >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (cmd_q.size() >= QUIET_TAIL && $urandom_range(0, 11) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(1, 19) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Check results first, then predict the item taken at this edge
	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					report_error($sformatf("result with no item waiting: st=%0d data=%h",
						status, data));
				end else begin
					want = want_q.pop_front();
					// fields: status/data/slot/count/at_end
					if (status !== want.status || data !== want.data || slot !== want.slot
							|| count !== want.count || at_end !== want.at_end)
						report_error($sformatf(
							"got %0d/%h/%0d/%0d/%b want %0d/%h/%0d/%0d/%b",
							status, data, slot, count, at_end, want.status, want.data,
							want.slot, want.count, want.at_end));
				end
			end
			if (in_valid && !in_stall) begin
				want_q.push_back(apply_command(cmd_t'(cmd), value, new_value, index));
				in_count <= in_count + 1;
			end
		end
	end

	// End the run when no item moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				dog_cycles <= 0;
			else
				dog_cycles <= dog_cycles + 1;
			if (dog_cycles >= DOG_LIMIT) begin
				$display("slot_table_with_match_and_nth_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		int total;
		mix_t mix;
		int p;
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_word[i] = '0;
		end
		walk_pos = 0;
		live_count = 0;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h0000_0001;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;

		// Directed: empty table, duplicates, nth past an equal value, walk to the end
		queue_cmd(CMD_NEXT, 32'h0, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_READ_NTH, 32'h0, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_REM_NTH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b0);
		queue_cmd(CMD_REM_VAL, 32'h0, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 6'd63, 1'b0);
		queue_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_ADD, 32'h0, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_ADD, 32'h7, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_ADD, 32'h7, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_REM_NTH, 32'h0, 32'h0, 6'd4, 1'b0);
		queue_cmd(CMD_READ_NTH, 32'h0, 32'h0, 6'd1, 1'b0);
		queue_cmd(CMD_READ_NTH, 32'h0, 32'h0, 6'd63, 1'b0);
		for (int i = 0; i < 5; i++)
			queue_cmd(CMD_NEXT, 32'h0, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_REPLACE, 32'h0, 32'h8000_0000, 6'd0, 1'b0);
		queue_cmd(CMD_REPLACE, 32'h1234_5678, 32'hFFFF_FFFF, 6'd0, 1'b0);
		queue_cmd(CMD_REM_VAL, 32'hFFFF_FFFF, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_REWIND, 32'h0, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_NEXT, 32'h0, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_ADD, 32'h1, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_CLEAR, 32'h0, 32'h0, 6'd0, 1'b0);
		queue_cmd(CMD_NEXT, 32'h0, 32'h0, 6'd0, 1'b0);

		// Random: fill past full first, then mixed phases with drain pauses
		queue_cmd(CMD_ADD, pick_value(), pick_value(), 6'($urandom_range(0, 63)), 1'b1);
		queue_phase(MIX_FILL, 110);
		queue_phase(MIX_WALK, 60);
		queue_phase(MIX_DRAIN, 60);
		total = 231;
		while (total < RANDOM_ITEMS) begin
			p = $urandom_range(0, 99);
			mix = (p < 35) ? MIX_FILL : (p < 60) ? MIX_WALK : (p < 85) ? MIX_DRAIN : MIX_ANY;
			if (total > RANDOM_ITEMS / 2 && total < RANDOM_ITEMS / 2 + 100) begin
				queue_cmd(CMD_NEXT, pick_value(), pick_value(), 6'($urandom_range(0, 63)),
					1'b1);
				total++;
			end
			p = $urandom_range(30, 100);
			queue_phase(mix, p);
			total += p;
		end

		// Reset, then release it at a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (cmd_q.size() == 0 && !in_valid && want_q.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (want_q.size() != 0)
			report_error($sformatf("%0d results never arrived", want_q.size()));
		if (errors == 0)
			$display("slot_table_with_match_and_nth_top verification clean");
		else
			$display("slot_table_with_match_and_nth_top verification failed");
		$finish;
	end

endmodule
